// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the encoder rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while reset is released
`define CV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define CV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define CV_ASSERT(lbl, clk, rst_n, prop)
`define CV_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/cvenc_pkg.sv =====
// shared types and constants for the rate one half convolutional encoder
// no dependencies
package cvenc_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned GEN_W  = 8;
  localparam int unsigned IDX_W  = 8;

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_FIRST_GEN  = 8'd0;
  localparam logic [IDX_W-1:0] REG_SECOND_GEN = 8'd1;

  // generator values after reset
  localparam logic [GEN_W-1:0] FIRST_GEN_RST  = 8'h03;
  localparam logic [GEN_W-1:0] SECOND_GEN_RST = 8'h02;

  typedef struct packed {
    logic [GEN_W-1:0] first_gen;
    logic [GEN_W-1:0] second_gen;
  } cvenc_cfg_t;

endpackage

// ===== rtl/core/cvenc_cfg_regs.sv =====
// generator mask registers behind the config write port
// depends on cvenc_pkg
module cvenc_cfg_regs
  import cvenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [GEN_W-1:0] cfg_data,
  output cvenc_cfg_t       cfg
);

  cvenc_cfg_t cfg_r;
  cvenc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_GEN:  cfg_nxt.first_gen  = cfg_data;
        REG_SECOND_GEN: cfg_nxt.second_gen = cfg_data;
        default:        cfg_nxt = cfg_r; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_gen  <= FIRST_GEN_RST;
      cfg_r.second_gen <= SECOND_GEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/cvenc_encoder.sv =====
// combinational encode of one byte: eight code bit pairs and the new history
// depends on cvenc_pkg
module cvenc_encoder
  import cvenc_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic [HISTORY_BITS-1:0] history,
  input  logic [DATA_W-1:0]       data,
  input  cvenc_cfg_t              cfg,
  output logic [CODE_W-1:0]       code_low,
  output logic [CODE_W-1:0]       code_high,
  output logic [HISTORY_BITS-1:0] history_nxt
);

  localparam int unsigned EXT_W = HISTORY_BITS + DATA_W;

  logic [EXT_W-1:0]        ext;
  logic [HISTORY_BITS-1:0] gen_a;
  logic [HISTORY_BITS-1:0] gen_b;
  logic [2*DATA_W-1:0]     pairs;

  // mask bits above the history width see zeros
  assign gen_a = cfg.first_gen[HISTORY_BITS-1:0];
  assign gen_b = cfg.second_gen[HISTORY_BITS-1:0];

  // old history on top, data bit 0 just below it, so every window is a slice
  always_comb begin
    ext[EXT_W-1 -: HISTORY_BITS] = history;
    for (int i = 0; i < DATA_W; i++) begin
      ext[DATA_W-1-i] = data[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      pairs[2*i]   = ^(ext[DATA_W-1-i +: HISTORY_BITS] & gen_a);
      pairs[2*i+1] = ^(ext[DATA_W-1-i +: HISTORY_BITS] & gen_b);
    end
  end

  assign code_low    = pairs[CODE_W-1:0];
  assign code_high   = pairs[2*CODE_W-1:CODE_W];
  assign history_nxt = ext[HISTORY_BITS-1:0];

endmodule

// ===== rtl/core/rate_half_convolutional_encoder.sv =====
// top level of the rate one half convolutional encoder
// depends on cvenc_pkg, cvenc_cfg_regs, cvenc_encoder and assert_macros.svh
//
// usage
//   in channel: one data byte per beat plus a last_in_packet flag; bit 0 is
//   encoded first. out channel: one beat per input beat carrying two code
//   bytes, pairs for data bits 0..3 in code_low_byte and 4..7 in
//   code_high_byte, first code bit in the lower position of each pair.
//   cfg channel: index 0 writes the first generator mask, index 1 the second;
//   other indexes are dropped. cfg_ready is always high; write only while idle.
//   pipeline: an accepted beat is held in the input register, then encoded
//   into the output register; one beat per cycle while out_ready stays high;
//   both registers form a two deep pipeline around one level of parity logic.
//   stall: when out_ready is low the output register holds, the input
//   register fills, and in_ready drops only once both are full.
//   reset (rst_n low, synchronous): both pipeline stages empty, history zero,
//   generators back to 0x03 and 0x02.
//   the history clears after a beat flagged last_in_packet has been encoded.
`include "assert_macros.svh"

module rate_half_convolutional_encoder
  import cvenc_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // data in
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data_byte,
  input  logic              in_last_in_packet,
  // code out
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_code_low_byte,
  output logic [CODE_W-1:0] out_code_high_byte,
  // config writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [GEN_W-1:0]  cfg_data
);

  cvenc_cfg_t cfg;

  // input register stage
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_last_r;

  // encoder state and output register stage
  logic [HISTORY_BITS-1:0] history_r;
  logic                    out_valid_r;
  logic [CODE_W-1:0]       code_low_r;
  logic [CODE_W-1:0]       code_high_r;

  logic [CODE_W-1:0]       enc_low;
  logic [CODE_W-1:0]       enc_high;
  logic [HISTORY_BITS-1:0] enc_history;

  logic out_free;   // output register can take a result this cycle
  logic advance;    // stage one moves into the output register
  logic in_fire;

  cvenc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvenc_encoder #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_enc (
    .history     (history_r),
    .data        (s1_data_r),
    .cfg         (cfg),
    .code_low    (enc_low),
    .code_high   (enc_high),
    .history_nxt (enc_history)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  // stage one frees up when it is empty or draining this cycle
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_in_packet;
    end
  end

  // history moves only when a byte is actually encoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '0;
    end else if (advance) begin
      history_r <= s1_last_r ? '0 : enc_history;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_low_r  <= enc_low;
      code_high_r <= enc_high;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_low_byte  = code_low_r;
  assign out_code_high_byte = code_high_r;

  // reset empties both stages
  `CV_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !s1_valid_r && !out_valid_r)
  // an encoded last byte leaves a clear history
  `CV_ASSERT(a_last_clears, clk, rst_n, advance && s1_last_r |=> history_r == '0)
  // a blocked stage one keeps its byte and the history stays put
  `CV_ASSERT(a_s1_hold, clk, rst_n,
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_data_r) && $stable(history_r))
  // every encoded byte lands in the output register
  `CV_ASSERT(a_advance_out, clk, rst_n, advance |=> out_valid_r)
  // an accepted byte always finds stage one
  `CV_ASSERT(a_in_lands, clk, rst_n, in_fire |=> s1_valid_r)

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for rate_half_convolutional_encoder
// holds its own encoder predictor, a queued beat driver and a result monitor
// depends on cvenc_pkg and the encoder rtl only
module tb_top
  import cvenc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_W = 8;
  localparam logic [GEN_W-1:0] HIST_MASK = GEN_W'((1 << HIST_W) - 1);
  // first index past the defined registers, used for dropped writes
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = REG_SECOND_GEN + 1'b1;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = '1;

  // what the driver does with one queued entry
  typedef enum logic [1:0] {
    OP_BEAT,
    OP_REG_WRITE,
    OP_WAIT_IDLE
  } op_kind_t;

  typedef struct {
    op_kind_t          kind;
    logic [DATA_W-1:0] data;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  value;
    int unsigned       idle_pct;
  } op_t;

  typedef struct packed {
    logic [CODE_W-1:0] high;
    logic [CODE_W-1:0] low;
  } code_pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic              in_last_in_packet = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] out_code_low_byte;
  logic [CODE_W-1:0] out_code_high_byte;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [GEN_W-1:0]  cfg_data = '0;

  // stimulus queue and expected code bytes
  op_t        stim_q[$];
  code_pair_t pending_codes[$];

  // predictor state, mirrors the block's registers
  logic [GEN_W-1:0] gen_first;
  logic [GEN_W-1:0] gen_second;
  logic [GEN_W-1:0] shift_hist;

  // run bookkeeping
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned packets_closed = 0;
  int unsigned reg_writes = 0;
  int unsigned dropped_writes = 0;
  int unsigned codes_checked = 0;
  int unsigned stall_pct = 0;

  always #10 clk = ~clk;

  rate_half_convolutional_encoder #(
    .HISTORY_BITS(HIST_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_in_packet (in_last_in_packet),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_low_byte (out_code_low_byte),
    .out_code_high_byte(out_code_high_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // shift the byte in lsb first, two parity bits per data bit
  task automatic encode_byte(input logic [DATA_W-1:0] data, input logic last);
    logic [2*CODE_W-1:0] code;
    code = '0;
    for (int i = 0; i < DATA_W; i++) begin
      shift_hist = {shift_hist[GEN_W-2:0], data[i]} & HIST_MASK;
      code[2*i]   = ^(shift_hist & gen_first);
      code[2*i+1] = ^(shift_hist & gen_second);
    end
    // packet boundary wipes the history
    if (last) begin
      shift_hist = '0;
    end
    pending_codes.push_back(code_pair_t'(code));
  endtask

  task automatic apply_reg_write(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] value);
    case (idx)
      REG_FIRST_GEN: begin
        gen_first = value;
      end
      REG_SECOND_GEN: begin
        gen_second = value;
      end
      default: begin
        // unmapped index, the block drops it
        dropped_writes++;
      end
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: pops the stimulus queue, predicts on every accepted beat
  // ---------------------------------------------------------------------------
  op_t         cur_op;
  bit          lane_free;
  bit          holding = 1'b0;
  bit          next_in_valid;
  bit          next_cfg_valid;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      gen_first  = FIRST_GEN_RST;
      gen_second = SECOND_GEN_RST;
      shift_hist = '0;
      gap_left   = 0;
      holding    = 1'b0;
    end else begin
      lane_free = 1'b1;
      // retire whatever was handed over at this edge
      if (in_valid) begin
        if (in_ready) begin
          encode_byte(in_data_byte, in_last_in_packet);
          beats_sent++;
          if (in_last_in_packet) begin
            packets_closed++;
          end
        end else begin
          lane_free = 1'b0;
        end
      end
      if (cfg_valid) begin
        if (cfg_ready) begin
          apply_reg_write(cfg_index, cfg_data);
        end else begin
          lane_free = 1'b0;
        end
      end
      next_in_valid  = 1'b0;
      next_cfg_valid = 1'b0;
      if (!lane_free) begin
        // payload stays put until the beat goes through
        next_in_valid  = in_valid;
        next_cfg_valid = cfg_valid;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (holding) begin
        // sender parked until the block has handed back every code pair
        if (pending_codes.size() == 0) begin
          holding = 1'b0;
        end
      end else if (stim_q.size() > 0) begin
        cur_op = stim_q.pop_front();
        case (cur_op.kind)
          OP_BEAT: begin
            next_in_valid = 1'b1;
            in_data_byte      <= cur_op.data;
            in_last_in_packet <= cur_op.last;
            stall_pct = cur_op.idle_pct;
            if ($urandom_range(0, 99) < cur_op.idle_pct) begin
              gap_left = $urandom_range(1, 16);
            end
          end
          OP_REG_WRITE: begin
            next_cfg_valid = 1'b1;
            cfg_index <= cur_op.idx;
            cfg_data  <= cur_op.value;
          end
          OP_WAIT_IDLE: begin
            holding = 1'b1;
          end
          default: begin
          end
        endcase
      end
      // a single update per edge keeps back to back beats glitch free
      in_valid  <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each code beat, stalls out_ready in random bursts
  // ---------------------------------------------------------------------------
  code_pair_t  want;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_codes.size() == 0) begin
          report_mismatch($sformatf("code beat with nothing expected, low %02h high %02h",
                                    out_code_low_byte, out_code_high_byte));
        end else begin
          want = pending_codes.pop_front();
          codes_checked++;
          if (out_code_low_byte !== want.low) begin
            report_mismatch($sformatf("code_low_byte got %02h want %02h",
                                      out_code_low_byte, want.low));
          end
          if (out_code_high_byte !== want.high) begin
            report_mismatch($sformatf("code_high_byte got %02h want %02h",
                                      out_code_high_byte, want.high));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        // this cycle counts as the first of the burst
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_beat(input logic [DATA_W-1:0] data, input logic last,
                          input int unsigned pct);
    op_t op;
    op.kind     = OP_BEAT;
    op.data     = data;
    op.last     = last;
    op.idx      = '0;
    op.value    = '0;
    op.idle_pct = pct;
    stim_q.push_back(op);
  endtask

  task automatic add_write(input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] value);
    op_t op;
    op.kind     = OP_REG_WRITE;
    op.data     = '0;
    op.last     = 1'b0;
    op.idx      = idx;
    op.value    = value;
    op.idle_pct = 0;
    stim_q.push_back(op);
  endtask

  task automatic add_wait_idle();
    op_t op;
    op.kind     = OP_WAIT_IDLE;
    op.data     = '0;
    op.last     = 1'b0;
    op.idx      = '0;
    op.value    = '0;
    op.idle_pct = 0;
    stim_q.push_back(op);
  endtask

  function automatic logic [GEN_W-1:0] pick_generator();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return GEN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sequence: directed corners, random phases, quiet tail, verdict
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rand_beats;
    int unsigned phase_len;
    int unsigned pct;

    // reset generators: all-zero, all-one, single bits, alternating patterns
    add_beat(8'h00, 1'b0, 0);
    add_beat(8'hFF, 1'b0, 0);
    add_beat(8'hFF, 1'b1, 0);
    add_beat(8'h01, 1'b0, 0);
    add_beat(8'h80, 1'b1, 0);
    add_beat(8'hAA, 1'b0, 0);
    add_beat(8'h55, 1'b1, 0);
    // full mask on the first code bit, empty mask on the second
    add_wait_idle();
    add_write(REG_FIRST_GEN, 8'hFF);
    add_write(REG_SECOND_GEN, 8'h00);
    add_beat(8'hFF, 1'b0, 0);
    add_beat(8'h0F, 1'b1, 0);
    add_beat(8'h96, 1'b0, 0);
    // swapped extremes
    add_wait_idle();
    add_write(REG_FIRST_GEN, 8'h00);
    add_write(REG_SECOND_GEN, 8'hFF);
    add_beat(8'hC3, 1'b0, 0);
    add_beat(8'h3C, 1'b1, 0);
    // writes to unmapped indexes must leave both masks alone
    add_wait_idle();
    add_write(REG_UNUSED_LO, 8'h5A);
    add_write(REG_UNUSED_HI, 8'hA5);
    add_beat(8'h81, 1'b0, 0);
    add_beat(8'h7E, 1'b1, 0);
    // constraint length seven pair, impulse response first
    add_wait_idle();
    add_write(REG_FIRST_GEN, 8'h79);
    add_write(REG_SECOND_GEN, 8'h5B);
    add_beat(8'h01, 1'b1, 0);
    add_beat(8'hE4, 1'b0, 0);
    add_beat(8'h1B, 1'b1, 0);
    // taps only on the oldest history bits, so bits shifted out get dropped
    add_wait_idle();
    add_write(REG_FIRST_GEN, 8'h80);
    add_write(REG_SECOND_GEN, 8'h40);
    add_beat(8'hFF, 1'b0, 0);
    add_beat(8'h00, 1'b0, 0);
    add_beat(8'h00, 1'b1, 0);

    // random phases, new masks between phases while idle
    rand_beats = 0;
    while (rand_beats < 1560) begin
      add_wait_idle();
      add_write(REG_FIRST_GEN, pick_generator());
      add_write(REG_SECOND_GEN, pick_generator());
      if ($urandom_range(0, 3) == 0) begin
        add_write(IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  GEN_W'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 5;
        2:       pct = 25;
        default: pct = 50;
      endcase
      phase_len = $urandom_range(80, 160);
      for (int n = 0; n < phase_len; n++) begin
        add_beat(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, pct);
        // occasional drain in the middle of a phase
        if ($urandom_range(0, 199) == 0) begin
          add_wait_idle();
        end
      end
      rand_beats += phase_len;
    end
    // quiet tail: back to back beats, no stalls
    add_wait_idle();
    add_write(REG_FIRST_GEN, pick_generator());
    add_write(REG_SECOND_GEN, pick_generator());
    for (int n = 0; n < 100; n++) begin
      add_beat(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // all stimulus handed over, then the pipeline drains
    do begin
      @(posedge clk);
    end while (stim_q.size() != 0 || holding || in_valid || cfg_valid);
    while (pending_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);

    $display("run covered %0d data beats in %0d closed packets, %0d code beats checked",
             beats_sent, packets_closed, codes_checked);
    $display("generator writes: %0d, of which %0d to unmapped indexes",
             reg_writes, dropped_writes);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #8ms;
    $display("timeout waiting for the encoder");
    $display("status: fail");
    $finish;
  end

endmodule
